// ----- rtl/pxfd_pkg.sv -----
// pxfd_pkg: shared types and constants of the prefixed XOR frame deframer.
// No dependencies.
`default_nettype none
package pxfd_pkg;

  localparam logic [7:0] BYTE_ACK       = 8'h06;
  localparam logic [7:0] BYTE_NAK       = 8'h15;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd3;

  localparam logic [0:0] REG_PREFIX_BYTE = 1'd0;
  localparam logic [0:0] REG_MIN_LENGTH  = 1'd1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NAK          = 3'd1,
    ST_BAD_PREFIX   = 3'd2,
    ST_TOO_SHORT    = 3'd3,
    ST_BAD_CHECKSUM = 3'd4,
    ST_INCOMPLETE   = 3'd5
  } status_t;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } command_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    status_t    status;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/prefixed_xor_frame_deframer_unit.sv -----
// prefixed_xor_frame_deframer_unit: deframer top level, frame state and result buffering.
// Depends on pxfd_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------
//  in      | in_valid, in_stall | command, rx_byte
//  out     | out_valid, out_stall | is_status, data_byte, status, last
//  cfg     | cfg_write          | cfg_index, cfg_data
//
// One item a cycle while in_stall is low; a result is registered into out, or into skid while out stalls.
// The frame state updates in the cycle of acceptance; the output register plus a
// one-entry skid stage keep input flowing while a result waits.
// in_stall rises only while the skid stage holds an item.
// Synchronous reset returns to idle with prefix 0x02 and minimum length 3.
`default_nettype none
module prefixed_xor_frame_deframer_unit (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               command,
  input  wire  [7:0]        rx_byte,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              is_status,
  output logic [7:0]        data_byte,
  output logic [2:0]        status,
  output logic              last,
  input  wire               cfg_write,
  input  wire  [0:0]        cfg_index,
  input  wire  [8:0]        cfg_data
);
  import pxfd_pkg::*;

  logic [7:0] prefix_byte;
  logic [8:0] min_answer_length;

  phase_t     phase, phase_next;
  logic [8:0] byte_count, byte_count_next;
  logic [8:0] frame_length, frame_length_next;
  logic [7:0] xor_sum, xor_sum_next;
  logic       prefix_wrong, prefix_wrong_next;

  result_t    res;
  logic       res_valid;
  result_t    out_reg, skid;
  logic       skid_valid;
  logic       accept;
  logic [8:0] count_inc;

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign count_inc = byte_count + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_byte       <= 8'h02;
      min_answer_length <= 9'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PREFIX_BYTE: prefix_byte       <= cfg_data[7:0];
        REG_MIN_LENGTH:  min_answer_length <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic result_t status_item(status_t st);
    result_t r;
    r.is_status = 1'b1;
    r.data_byte = 8'h00;
    r.status    = st;
    r.last      = 1'b1;
    return r;
  endfunction

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    xor_sum_next      = xor_sum;
    prefix_wrong_next = prefix_wrong;
    res_valid         = 1'b0;
    res               = status_item(ST_OK);
    if (command_t'(command) == CMD_TIMEOUT) begin
      res_valid = 1'b1;
      if (byte_count < min_answer_length) res = status_item(ST_TOO_SHORT);
      else if (byte_count != 9'd0 && prefix_wrong) res = status_item(ST_BAD_PREFIX);
      else res = status_item(ST_INCOMPLETE);
    end else begin
      unique case (phase)
        PH_LENGTH: begin
          frame_length_next = {1'b0, rx_byte} + FRAME_OVERHEAD;
          xor_sum_next      = rx_byte;
          byte_count_next   = 9'd2;
          phase_next        = PH_COLLECT;
        end
        PH_COLLECT: begin
          byte_count_next = count_inc;
          res_valid       = 1'b1;
          if (count_inc < frame_length) begin
            xor_sum_next  = xor_sum ^ rx_byte;
            res.is_status = 1'b0;
            res.data_byte = rx_byte;
            res.status    = ST_OK;
            res.last      = 1'b0;
          end else if (frame_length < min_answer_length) res = status_item(ST_TOO_SHORT);
          else if (prefix_wrong) res = status_item(ST_BAD_PREFIX);
          else if (rx_byte != xor_sum) res = status_item(ST_BAD_CHECKSUM);
          else res = status_item(ST_OK);
        end
        default: begin
          if (rx_byte == BYTE_NAK) begin
            res_valid = 1'b1;
            res       = status_item(ST_NAK);
          end else if (rx_byte != BYTE_ACK) begin
            prefix_wrong_next = (rx_byte != prefix_byte);
            byte_count_next   = 9'd1;
            frame_length_next = 9'd0;
            xor_sum_next      = 8'h00;
            phase_next        = PH_LENGTH;
          end
        end
      endcase
    end
    // any status item closes the answer
    if (res_valid && res.is_status) begin
      phase_next        = PH_IDLE;
      byte_count_next   = 9'd0;
      frame_length_next = 9'd0;
      xor_sum_next      = 8'h00;
      prefix_wrong_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= 9'd0;
      frame_length <= 9'd0;
      xor_sum      <= 8'h00;
      prefix_wrong <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      xor_sum      <= xor_sum_next;
      prefix_wrong <= prefix_wrong_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_reg    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (out_valid && out_stall) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end else begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign is_status = out_reg.is_status;
  assign data_byte = out_reg.data_byte;
  assign status    = out_reg.status;
  assign last      = out_reg.last;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds an item with output empty");
  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> byte_count != 9'd0) else $error("open frame with zero count");
  a_timeout_idles: assert property (@(posedge clk) disable iff (rst)
    accept && command_t'(command) == CMD_TIMEOUT |=> phase == PH_IDLE && byte_count == 9'd0)
    else $error("timeout did not close the answer");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_status == last) else $error("last does not match status item");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_prefixed_xor_frame_deframer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for prefixed_xor_frame_deframer_unit: directed answers from a table,
// then random answer streams under several register settings and idle patterns.
// Depends on pxfd_pkg and the deframer RTL.
module tb_prefixed_xor_frame_deframer_unit;
  import pxfd_pkg::*;

  localparam int STUCK_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 215;

  typedef struct packed {
    command_t   cmd;
    logic [7:0] rx;
    logic       typed;
    logic       has;
    logic       stat;
    logic [7:0] data;
    status_t    st;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       command;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       is_status;
  logic [7:0] data_byte;
  logic [2:0] status;
  logic       last;
  logic       cfg_write;
  logic [0:0] cfg_index;
  logic [8:0] cfg_data;

  // frame tracker state and register copies
  phase_t     ph;
  logic [8:0] frame_cnt;
  logic [8:0] frame_len;
  logic [7:0] run_xor;
  logic       prefix_bad;
  logic [7:0] cur_prefix;
  logic [8:0] cur_min_len;

  result_t    answer_q [$];
  dir_row_t   directed [22];
  int         errors = 0;
  int         sent = 0;
  int         stuck = 0;
  int         src_idle_pct;
  int         dst_idle_pct;
  bit         hold_req;

  prefixed_xor_frame_deframer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_status (is_status),
    .data_byte (data_byte),
    .status    (status),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t end_answer(input status_t st);
    end_answer = '{is_status: 1'b1, data_byte: 8'h00, status: st, last: 1'b1};
    ph = PH_IDLE;
    frame_cnt = '0;
    frame_len = '0;
    run_xor = '0;
    prefix_bad = 1'b0;
  endfunction

  function automatic void deframe(input command_t c, input logic [7:0] b,
                                  output logic has, output result_t r);
    has = 1'b1;
    r = '{is_status: 1'b0, data_byte: b, status: ST_OK, last: 1'b0};
    if (c == CMD_TIMEOUT) begin
      if (frame_cnt < cur_min_len) r = end_answer(ST_TOO_SHORT);
      else if (frame_cnt != 9'd0 && prefix_bad) r = end_answer(ST_BAD_PREFIX);
      else r = end_answer(ST_INCOMPLETE);
    end else begin
      case (ph)
        PH_LENGTH: begin
          frame_len = {1'b0, b} + FRAME_OVERHEAD;
          run_xor = b;
          frame_cnt = 9'd2;
          ph = PH_COLLECT;
          has = 1'b0;
        end
        PH_COLLECT: begin
          frame_cnt = frame_cnt + 9'd1;
          if (frame_cnt < frame_len) run_xor = run_xor ^ b;
          else if (frame_len < cur_min_len) r = end_answer(ST_TOO_SHORT);
          else if (prefix_bad) r = end_answer(ST_BAD_PREFIX);
          else if (b != run_xor) r = end_answer(ST_BAD_CHECKSUM);
          else r = end_answer(ST_OK);
        end
        default: begin
          if (b == BYTE_NAK) begin
            r = end_answer(ST_NAK);
          end else if (b == BYTE_ACK) begin
            has = 1'b0;
          end else begin
            prefix_bad = (b != cur_prefix);
            frame_cnt = 9'd1;
            frame_len = '0;
            run_xor = '0;
            ph = PH_LENGTH;
            has = 1'b0;
          end
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // typed rows carry their own expectation, pushed by the caller
  task automatic send_item(input command_t c, input logic [7:0] b, input bit typed = 1'b0);
    logic    has;
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    deframe(c, b, has, r);
    if (has && !typed) answer_q.push_back(r);
    sent++;
  endtask

  // force_len >= 0 gives an uncut frame of that payload length with a correct checksum (prefix may be random)
  task automatic send_answer(input int force_len);
    int         kind;
    int         len;
    int         cut;
    logic [7:0] lead;
    logic [7:0] x;
    logic [7:0] b;
    logic [7:0] frame_bytes [$];
    kind = (force_len >= 0) ? 99 : $urandom_range(99);
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0) send_item(CMD_BYTE, BYTE_ACK);
    if (kind < 6) begin
      send_item(CMD_BYTE, BYTE_NAK);
    end else if (kind < 10) begin
      send_item(CMD_TIMEOUT, 8'($urandom));
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 6)) send_item(CMD_BYTE, 8'($urandom));
      send_item(CMD_TIMEOUT, 8'($urandom));
    end else begin
      lead = cur_prefix;
      if ($urandom_range(9) == 0) lead = 8'($urandom);
      if (lead == BYTE_ACK || lead == BYTE_NAK) lead ^= 8'h80;
      if (force_len >= 0) len = force_len;
      else if ($urandom_range(79) == 0) len = $urandom_range(1) ? 255 : $urandom_range(13, 254);
      else len = $urandom_range(0, 12);
      x = len[7:0];
      frame_bytes.push_back(lead);
      frame_bytes.push_back(len[7:0]);
      repeat (len) begin
        b = 8'($urandom);
        x ^= b;
        frame_bytes.push_back(b);
      end
      frame_bytes.push_back((force_len < 0 && $urandom_range(4) == 0) ? 8'($urandom) : x);
      cut = (force_len < 0 && $urandom_range(7) == 0) ?
            $urandom_range(1, frame_bytes.size() - 1) : frame_bytes.size();
      for (int n = 0; n < cut; n++) send_item(CMD_BYTE, frame_bytes[n]);
      if (cut < frame_bytes.size()) send_item(CMD_TIMEOUT, 8'($urandom));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] pfx, input logic [8:0] min_len);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_PREFIX_BYTE;
    cfg_data <= {1'b0, pfx};
    @(posedge clk);
    cur_prefix = pfx;
    cfg_index <= REG_MIN_LENGTH;
    cfg_data <= min_len;
    @(posedge clk);
    cur_min_len = min_len;
    cfg_write <= 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected item", {is_status, data_byte, status, last}, 0);
      end else begin
        want = answer_q.pop_front();
        if (is_status !== want.is_status) report_mismatch("is_status", is_status, want.is_status);
        if (data_byte !== want.data_byte) report_mismatch("data_byte", data_byte, want.data_byte);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
      $display("tb_prefixed_xor_frame_deframer_unit: done, errors");
      $finish;
    end else begin
      stuck++;
    end
  end

  initial begin
    logic [7:0] pfx;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_BYTE;
    rx_byte = 8'h00;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_PREFIX_BYTE;
    cfg_data = 9'd0;
    hold_req = 1'b0;
    src_idle_pct = 14;
    dst_idle_pct = 46;
    cur_prefix = 8'h02;
    cur_min_len = 9'd3;
    void'(end_answer(ST_OK));
    directed = '{
      '{CMD_TIMEOUT, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, ST_TOO_SHORT},
      '{CMD_BYTE,    8'h06, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h06, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h15, 1'b1, 1'b1, 1'b1, 8'h00, ST_NAK},
      '{CMD_BYTE,    8'h02, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h02, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'hff, 1'b1, 1'b1, 1'b0, 8'hff, ST_OK},
      '{CMD_BYTE,    8'h00, 1'b1, 1'b1, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'hfd, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'hff, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h00, 1'b1, 1'b1, 1'b1, 8'h00, ST_BAD_PREFIX},
      '{CMD_BYTE,    8'h02, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h01, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h80, 1'b1, 1'b1, 1'b0, 8'h80, ST_OK},
      '{CMD_BYTE,    8'h00, 1'b1, 1'b1, 1'b1, 8'h00, ST_BAD_CHECKSUM},
      '{CMD_BYTE,    8'h02, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h05, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_BYTE,    8'h55, 1'b1, 1'b1, 1'b0, 8'h55, ST_OK},
      '{CMD_TIMEOUT, 8'hff, 1'b1, 1'b1, 1'b1, 8'h00, ST_INCOMPLETE},
      '{CMD_BYTE,    8'h00, 1'b1, 1'b0, 1'b0, 8'h00, ST_OK},
      '{CMD_TIMEOUT, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, ST_TOO_SHORT}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].typed && directed[i].has)
        answer_q.push_back('{is_status: directed[i].stat, data_byte: directed[i].data,
                             status: directed[i].st, last: directed[i].stat});
      send_item(command_t'(directed[i].cmd), directed[i].rx, directed[i].typed);
    end

    // receiver held off while a long frame streams in
    src_idle_pct = 0;
    hold_req = 1'b1;
    send_answer(40);

    for (int p = 0; p < 5; p++) begin
      src_idle_pct = (p < 2) ? 14 : (p < 4) ? 46 : 0;
      dst_idle_pct = (p < 2) ? 46 : (p < 4) ? 14 : 0;
      pfx = 8'($urandom);
      if (pfx == BYTE_ACK || pfx == BYTE_NAK) pfx ^= 8'h80;
      case (p)
        1: write_config(8'h00, 9'd0);
        2: write_config(8'hff, 9'd258);
        3: write_config(pfx, 9'($urandom_range(0, 20)));
        4: write_config(pfx, 9'd3);
        default: ;
      endcase
      for (int target = sent + PHASE_ITEMS; sent < target; ) send_answer(-1);
    end

    settle();
    if (errors == 0) begin
      $display("tb_prefixed_xor_frame_deframer_unit: done, clean");
    end else begin
      $display("tb_prefixed_xor_frame_deframer_unit: done, errors");
    end
    $finish;
  end

endmodule
